[hw/rtl/vcl_pkg.sv]
// Shared types, widths and codes for the value-to-colormap lookup block.
// No dependencies; every other file but vcl_ram imports this package.
package vcl_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int SAMPLE_WIDTH = 64;

    localparam int CFG_W   = 64;
    localparam int COLOR_W = 24;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W  = CFG_W + LEN_W;
    localparam int CNT_W   = $clog2(IDX_W + 1);

    typedef enum logic [1:0] {
        REG_START_VALUE   = 2'd0,
        REG_END_VALUE     = 2'd1,
        REG_TABLE_LENGTH  = 2'd2,
        REG_ONLY_SELECTED = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_LOAD   = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV,
        DV_FIN
    } div_state_t;

    typedef struct packed {
        logic                           kind;
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic                           selected;
        logic [7:0]                     entry_index;
        logic [23:0]                    entry_color;
    } vcl_in_t;

    typedef struct packed {
        logic [7:0] color_red;
        logic [7:0] color_green;
        logic [7:0] color_blue;
        logic       recolored;
        logic [7:0] table_position;
    } vcl_out_t;

endpackage

[hw/rtl/vcl_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM, registered read data.
// No package dependencies.
module vcl_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/vcl_scale_div.sv]
// Serial unit for floor(offset * len / span): shift-add multiply, then restoring divide.
// Depends on vcl_pkg.
module vcl_scale_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [vcl_pkg::CFG_W-1:0] offset,
    input  logic [vcl_pkg::CFG_W-1:0] span,
    input  logic [vcl_pkg::LEN_W-1:0] len,
    output logic                     done,
    output logic [vcl_pkg::IDX_W-1:0] quotient
);
    import vcl_pkg::*;

    div_state_t         phase_reg, phase_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0]  mcand_reg, mcand_next;
    logic [LEN_W-1:0]   mplier_reg, mplier_next;
    logic [CFG_W-1:0]   span_reg, span_next;
    logic [PROD_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   q_reg, q_next;
    logic               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DV_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        span_reg   <= span_next;
        dsr_reg    <= dsr_next;
        cnt_reg    <= cnt_next;
        q_reg      <= q_next;
    end

    assign fits = (acc_reg >= dsr_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        span_next   = span_reg;
        dsr_next    = dsr_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        case (phase_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = PROD_W'(offset);
                    mplier_next = len;
                    span_next   = span;
                    phase_next  = DV_MUL;
                end
            end
            DV_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    dsr_next   = PROD_W'(span_reg) << (IDX_W - 1);
                    cnt_next   = CNT_W'(IDX_W - 1);
                    q_next     = '0;
                    phase_next = DV_DIV;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            DV_DIV:
            begin
                if (fits)
                begin
                    acc_next = acc_reg - dsr_reg;
                end
                q_next   = IDX_W'({q_reg, fits});
                dsr_next = dsr_reg >> 1;
                if (cnt_reg == '0)
                begin
                    phase_next = DV_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            DV_FIN:
            begin
                phase_next = DV_IDLE;
            end
            default:
            begin
                phase_next = DV_IDLE;
            end
        endcase
    end

    assign done     = (phase_reg == DV_FIN);
    assign quotient = q_reg;
endmodule

[hw/rtl/value_to_colormap_lookup.sv]
// Top level of the value-to-colormap lookup: config registers, control FSM, table RAM.
// Depends on vcl_pkg, vcl_ram and vcl_scale_div.
//
// Maps a signed sample onto a gradient table held in a synchronous RAM. Load beats
// (kind 1) write one entry in the cycle they are accepted and return nothing.
// Sample beats (kind 0) return one result beat. One sample is in flight at a time:
// a skipped or an empty-table sample goes from evaluation straight to the finish
// step; a sample clamped to either end of the range first goes through a table read;
// a sample inside the range runs through the serial scale-divide unit, up to LEN_W
// shift-add plus IDX_W restoring-divide steps, then a table read. A finished result
// waits in the output register while the next beat is accepted. Entries read
// before they are written return undefined colours.
module value_to_colormap_lookup (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  vcl_pkg::vcl_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output vcl_pkg::vcl_out_t         out_data,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [vcl_pkg::CFG_W-1:0] cfg_data
);
    import vcl_pkg::*;

    logic signed [CFG_W-1:0] start_reg;
    logic signed [CFG_W-1:0] end_reg;
    logic [8:0]              length_reg;
    logic                    only_sel_reg;

    state_t         state_reg, state_next;
    logic           out_valid_reg, out_valid_next;
    vcl_out_t       out_data_reg, out_data_next;
    vcl_in_t        item_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic           rec_reg, rec_next;
    logic           use_ram_reg, use_ram_next;

    logic             in_beat;
    logic [LEN_W-1:0] len_eff;
    logic signed [CFG_W-1:0] v;
    logic [CFG_W-1:0] div_offset;
    logic [CFG_W-1:0] div_span;
    logic             div_start;
    logic             div_done;
    logic [IDX_W-1:0] div_q;
    logic             ram_we;
    logic             ram_re;
    logic [COLOR_W-1:0] ram_rdata;
    logic             slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign ram_we    = in_beat && (in_data.kind == KIND_LOAD)
                       && (int'(in_data.entry_index) < TABLE_DEPTH);
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            end_reg      <= '0;
            length_reg   <= '0;
            only_sel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_VALUE:   start_reg    <= cfg_data;
                REG_END_VALUE:     end_reg      <= cfg_data;
                REG_TABLE_LENGTH:  length_reg   <= cfg_data[8:0];
                REG_ONLY_SELECTED: only_sel_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign len_eff = (int'(length_reg) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                      : LEN_W'(length_reg);
    assign v = CFG_W'(item_reg.sample_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            item_reg <= in_data;
        end
        idx_reg      <= idx_next;
        rec_reg      <= rec_next;
        use_ram_reg  <= use_ram_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        rec_next       = rec_reg;
        use_ram_next   = use_ram_reg;
        div_start      = 1'b0;
        div_offset     = CFG_W'(v - start_reg);
        div_span       = CFG_W'(end_reg - start_reg);
        ram_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (in_data.kind == KIND_SAMPLE))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                idx_next     = '0;
                rec_next     = 1'b1;
                use_ram_next = 1'b0;
                if (only_sel_reg && !item_reg.selected)
                begin
                    rec_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (len_eff == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (start_reg == end_reg)
                begin
                    if (v == start_reg)
                    begin
                        idx_next = IDX_W'(len_eff >> 1);
                    end
                    else if (v > start_reg)
                    begin
                        idx_next = IDX_W'(len_eff - 1'b1);
                    end
                    state_next = ST_READ;
                end
                else if (end_reg > start_reg)
                begin
                    if (v >= end_reg)
                    begin
                        idx_next   = IDX_W'(len_eff - 1'b1);
                        state_next = ST_READ;
                    end
                    else if (v <= start_reg)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    div_offset = CFG_W'(start_reg - v);
                    div_span   = CFG_W'(start_reg - end_reg);
                    if (v <= end_reg)
                    begin
                        idx_next   = IDX_W'(len_eff - 1'b1);
                        state_next = ST_READ;
                    end
                    else if (v >= start_reg)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_q;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re       = 1'b1;
                use_ram_next = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.recolored      = rec_reg;
                    out_data_next.table_position = 8'(idx_reg);
                    if (use_ram_reg)
                    begin
                        out_data_next.color_red   = ram_rdata[23:16];
                        out_data_next.color_green = ram_rdata[15:8];
                        out_data_next.color_blue  = ram_rdata[7:0];
                    end
                    else
                    begin
                        out_data_next.color_red   = '0;
                        out_data_next.color_green = '0;
                        out_data_next.color_blue  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    vcl_scale_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .offset   (div_offset),
        .span     (div_span),
        .len      (len_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    vcl_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (COLOR_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(in_data.entry_index)),
        .wdata (in_data.entry_color),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside the finish step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divide unit finished while control was not waiting on it");

    a_read_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (LEN_W'(idx_reg) < len_eff))
        else $error("table read at or beyond the active length");

    a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (in_data.kind == KIND_SAMPLE)) |=> !in_ready)
        else $error("new beat taken while a sample is in flight");
endmodule

[test/tb.sv]
// Testbench for value_to_colormap_lookup: directed plan, then random phases.
// Depends on vcl_pkg and the RTL; results checked against planned or predicted values.
module tb;
    import vcl_pkg::*;

    localparam logic signed [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam int LIMIT      = 500000;
    localparam int DRAIN      = 40;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 55;

    typedef enum logic { ROW_SETUP, ROW_BEAT } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic signed [63:0] s;
        logic signed [63:0] e;
        logic [8:0]        len;
        logic              osel;
        vcl_in_t           beat;
        logic              typed;
        vcl_out_t          want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    vcl_in_t           in_data;
    logic              out_valid;
    logic              out_ready;
    vcl_out_t          out_data;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    logic [23:0]        palette_copy [TABLE_DEPTH];
    logic signed [63:0] span_start;
    logic signed [63:0] span_end;
    logic [8:0]         palette_len;
    logic               selected_only;

    vcl_out_t  expected_colors [$];
    plan_row_t plan [$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        cycle_count = 0;
    bit        steady;

    value_to_colormap_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [23:0] fill_color(int i);
        logic [7:0] b;
        b = i[7:0];
        return {b, ~b, b ^ 8'h5a};
    endfunction

    function automatic vcl_out_t mk_result(logic [23:0] c, logic [7:0] pos);
        vcl_out_t r;
        r.color_red      = c[23:16];
        r.color_green    = c[15:8];
        r.color_blue     = c[7:0];
        r.recolored      = 1'b1;
        r.table_position = pos;
        return r;
    endfunction

    function automatic vcl_out_t lookup_color(vcl_in_t b);
        logic signed [63:0] v;
        logic [8:0]         len;
        logic [8:0]         pos;
        logic [63:0]        delta;
        logic [63:0]        span;
        logic [72:0]        prod;
        logic [72:0]        quo;
        vcl_out_t           r;
        r = '0;
        if (selected_only && !b.selected)
            return r;
        r.recolored = 1'b1;
        len = (palette_len > TABLE_DEPTH) ? 9'(TABLE_DEPTH) : palette_len;
        if (len == 9'd0)
            return r;
        v = b.sample_value;
        delta = '0;
        span = '1;
        if (span_start == span_end)
        begin
            if (v == span_start)
                pos = len >> 1;
            else if (v > span_start)
                pos = len - 9'd1;
            else
                pos = 9'd0;
        end
        else if (span_end > span_start)
        begin
            if (v <= span_start)
                pos = 9'd0;
            else if (v >= span_end)
                pos = len - 9'd1;
            else
            begin
                delta = v - span_start;
                span  = span_end - span_start;
                pos   = 9'd511;
            end
        end
        else
        begin
            if (v >= span_start)
                pos = 9'd0;
            else if (v <= span_end)
                pos = len - 9'd1;
            else
            begin
                delta = span_start - v;
                span  = span_start - span_end;
                pos   = 9'd511;
            end
        end
        if (pos == 9'd511)
        begin
            prod = delta * len;
            quo  = prod / {9'd0, span};
            pos  = quo[8:0];
            if (pos > len - 9'd1)
                pos = len - 9'd1;
        end
        return mk_result(palette_copy[pos[7:0]], pos[7:0]);
    endfunction

    task automatic plan_setup(logic signed [63:0] s, logic signed [63:0] e,
                              logic [8:0] len, logic osel);
        plan_row_t p;
        p = '{kind: ROW_SETUP, default: '0};
        p.kind = ROW_SETUP;
        p.s    = s;
        p.e    = e;
        p.len  = len;
        p.osel = osel;
        plan.push_back(p);
    endtask

    task automatic plan_sample(logic signed [63:0] v, logic sel, logic typed, vcl_out_t want);
        plan_row_t p;
        p = '{kind: ROW_BEAT, default: '0};
        p.kind              = ROW_BEAT;
        p.beat.kind         = KIND_SAMPLE;
        p.beat.sample_value = v;
        p.beat.selected     = sel;
        p.typed             = typed;
        p.want              = want;
        plan.push_back(p);
    endtask

    task automatic plan_load(logic [7:0] idx, logic [23:0] c);
        plan_row_t p;
        p = '{kind: ROW_BEAT, default: '0};
        p.kind              = ROW_BEAT;
        p.beat.kind         = KIND_LOAD;
        p.beat.sample_value = '1;
        p.beat.selected     = 1'b1;
        p.beat.entry_index  = idx;
        p.beat.entry_color  = c;
        plan.push_back(p);
    endtask

    task automatic issue_beat(vcl_in_t b, logic typed, vcl_out_t want);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (b.kind == KIND_LOAD)
            palette_copy[b.entry_index] = b.entry_color;
        else if (typed)
            expected_colors.push_back(want);
        else
            expected_colors.push_back(lookup_color(b));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_colors.size() != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic apply_config(logic signed [63:0] s, logic signed [63:0] e,
                                logic [63:0] len_word, logic [63:0] osel_word);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_VALUE;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= REG_END_VALUE;
        cfg_data  <= e;
        @(posedge clk);
        cfg_index <= REG_TABLE_LENGTH;
        cfg_data  <= len_word;
        @(posedge clk);
        cfg_index <= REG_ONLY_SELECTED;
        cfg_data  <= osel_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        span_start    = s;
        span_end      = e;
        palette_len   = len_word[8:0];
        selected_only = osel_word[0];
    endtask

    function automatic vcl_in_t random_beat();
        vcl_in_t            b;
        logic signed [63:0] lo;
        logic [63:0]        span;
        b.kind         = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_SAMPLE;
        b.selected     = ($urandom_range(0, 3) != 0);
        b.entry_index  = 8'($urandom_range(0, 255));
        b.entry_color  = 24'($urandom_range(0, 24'hffffff));
        lo   = (span_end > span_start) ? span_start : span_end;
        span = (span_end > span_start) ? span_end - span_start : span_start - span_end;
        case ($urandom_range(0, 9))
            0: b.sample_value = span_start;
            1: b.sample_value = span_end;
            2: b.sample_value = span_start + $signed(64'($urandom_range(0, 2))) - 64'sd1;
            3: b.sample_value = span_end + $signed(64'($urandom_range(0, 2))) - 64'sd1;
            4: b.sample_value = rand64();
            default:
                if (span == 64'd0)
                    b.sample_value = span_start + $signed(64'($urandom_range(0, 2))) - 64'sd1;
                else
                    b.sample_value = lo + (rand64() % span);
        endcase
        return b;
    endfunction

    task automatic random_config(int phase);
        logic signed [63:0] s;
        logic signed [63:0] e;
        logic [8:0]         len;
        case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(0, 5))
            0: begin s = S64_MIN; e = S64_MAX; end
            1: begin s = S64_MAX; e = S64_MIN; end
            2: begin s = rand64(); e = s; end
            3: begin s = rand64(); e = rand64(); end
            4: begin s = $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
                     e = s + $signed(64'($urandom_range(1, 5000))); end
            default: begin s = $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
                           e = s - $signed(64'($urandom_range(1, 5000))); end
        endcase
        case (phase < 2 ? 2 : $urandom_range(0, 7))
            0: len = 9'd0;
            1: len = 9'd1;
            2: len = 9'd256;
            3: len = 9'($urandom_range(257, 511));
            4: len = 9'd2;
            default: len = 9'($urandom_range(1, 256));
        endcase
        apply_config(s, e, {55'(rand64() >> 9), len},
                     {63'(rand64() >> 1), phase == 1 ? 1'b1 : 1'($urandom_range(0, 1))});
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_colors.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                vcl_out_t w;
                w = expected_colors.pop_front();
                check_field("color_red", int'(w.color_red), int'(out_data.color_red));
                check_field("color_green", int'(w.color_green), int'(out_data.color_green));
                check_field("color_blue", int'(w.color_blue), int'(out_data.color_blue));
                check_field("recolored", int'(w.recolored), int'(out_data.recolored));
                check_field("table_position", int'(w.table_position),
                            int'(out_data.table_position));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("value_to_colormap_lookup: mismatch");
            $finish;
        end
    end

    initial
    begin : receiver
        bit long_hold_done;
        long_hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= 150)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (steady || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        vcl_out_t skip_res;
        vcl_out_t empty_res;
        vcl_in_t  b;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_START_VALUE;
        cfg_data      = '0;
        steady        = 1'b0;
        span_start    = '0;
        span_end      = '0;
        palette_len   = '0;
        selected_only = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            palette_copy[i] = '0;
        skip_res  = '0;
        empty_res = mk_result(24'h0, 8'd0);

        plan_sample(64'sd0, 1'b0, 1'b1, empty_res);
        plan_sample(S64_MAX, 1'b1, 1'b1, empty_res);
        plan_setup(64'sd0, 64'sd0, 9'd0, 1'b1);
        plan_sample(-64'sd1, 1'b0, 1'b1, skip_res);
        plan_sample(S64_MIN, 1'b1, 1'b1, empty_res);
        plan_setup(S64_MIN, S64_MAX, 9'd256, 1'b0);
        plan_sample(S64_MIN, 1'b0, 1'b1, mk_result(fill_color(0), 8'd0));
        plan_sample(S64_MAX, 1'b0, 1'b1, mk_result(fill_color(255), 8'd255));
        plan_sample(64'sd0, 1'b0, 1'b0, skip_res);
        plan_sample(-64'sd1, 1'b1, 1'b0, skip_res);
        plan_sample(S64_MIN + 64'sd1, 1'b0, 1'b0, skip_res);
        plan_setup(S64_MAX, S64_MIN, 9'd256, 1'b0);
        plan_sample(S64_MAX, 1'b0, 1'b1, mk_result(fill_color(0), 8'd0));
        plan_sample(S64_MIN, 1'b0, 1'b1, mk_result(fill_color(255), 8'd255));
        plan_sample(64'sd0, 1'b0, 1'b0, skip_res);
        plan_setup(64'sd100, 64'sd100, 9'd256, 1'b0);
        plan_sample(64'sd100, 1'b0, 1'b1, mk_result(fill_color(128), 8'd128));
        plan_sample(64'sd101, 1'b0, 1'b1, mk_result(fill_color(255), 8'd255));
        plan_sample(64'sd99, 1'b0, 1'b1, mk_result(fill_color(0), 8'd0));
        plan_setup(-64'sd50, 64'sd50, 9'd1, 1'b0);
        plan_sample(64'sd0, 1'b0, 1'b1, mk_result(fill_color(0), 8'd0));
        plan_sample(S64_MAX, 1'b0, 1'b1, mk_result(fill_color(0), 8'd0));
        plan_setup(64'sd0, 64'sd1000, 9'd511, 1'b1);
        plan_sample(64'sd5000, 1'b1, 1'b1, mk_result(fill_color(255), 8'd255));
        plan_sample(64'sd999, 1'b1, 1'b0, skip_res);
        plan_sample(64'sd500, 1'b0, 1'b1, skip_res);
        plan_load(8'd255, 24'hffffff);
        plan_load(8'd0, 24'h000000);
        plan_sample(64'sd5000, 1'b1, 1'b1, mk_result(24'hffffff, 8'd255));
        plan_sample(-64'sd7, 1'b1, 1'b1, mk_result(24'h000000, 8'd0));
        plan_sample(64'sd500, 1'b1, 1'b0, skip_res);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every entry so no unwritten entry can be read
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            b = '0;
            b.kind         = KIND_LOAD;
            b.sample_value = rand64();
            b.selected     = 1'($urandom_range(0, 1));
            b.entry_index  = i[7:0];
            b.entry_color  = fill_color(i);
            issue_beat(b, 1'b0, skip_res);
        end

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_SETUP)
            begin
                settle();
                apply_config(plan[k].s, plan[k].e, {55'd0, plan[k].len}, {63'd0, plan[k].osel});
            end
            else
                issue_beat(plan[k].beat, plan[k].typed, plan[k].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            random_config(ph);
            steady = (ph == PHASES - 1);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (ph == 2 && n == PHASE_LEN / 2)
                begin
                    // hold input until the block has drained
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (expected_colors.size() != 0);
                end
                issue_beat(random_beat(), 1'b0, skip_res);
            end
        end

        settle();
        if (mismatches == 0)
            $display("value_to_colormap_lookup: match");
        else
            $display("value_to_colormap_lookup: mismatch");
        $finish;
    end
endmodule
